// ===== sv/bol_pkg.sv =====
// Shared types and constants for the bounded ordered list.
// No dependencies; the interfaces, the core and the testbench refer to it by scoped names.
package bol_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_LIST      = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOPOS = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// ===== sv/bol_if.sv =====
// Valid/ready channel interfaces for the list's command and result beats.
// Depends on bol_pkg for field widths.
interface bol_in_if;
  logic                               valid;
  logic                               ready;
  logic        [bol_pkg::OP_W-1:0]    op;
  logic signed [bol_pkg::VAL_W-1:0]   value;
  logic        [bol_pkg::POS_W-1:0]   position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

interface bol_out_if;
  logic                               valid;
  logic                               ready;
  logic        [bol_pkg::ST_W-1:0]    status;
  logic signed [bol_pkg::VAL_W-1:0]   value_res;
  logic                               last;

  modport source (output valid, status, value_res, last, input ready);
  modport sink   (input valid, status, value_res, last, output ready);
endinterface

// ===== sv/bol_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/bounded_ordered_list_core.sv =====
// Bounded ordered list: top level with the operation sequencer and result register.
// Depends on bol_pkg, bol_in_if, bol_out_if and bol_ram.
//
// Holds up to DEPTH signed 32-bit values front to back in one RAM with one write
// and one registered read port; all data movement goes through that port pair under
// a small sequencer, one command beat at a time (in_i.ready is high only when idle).
// With c values held, an insert at 1-based position p <= c shifts the c-p+1 values from
// p onward one place back; an insert back, or into an empty list, shifts nothing. Delete
// front shifts the c-1 values behind the head one place forward; delete back, list and
// errors shift nothing. The entry moves and the list read-out are set by the single RAM
// port pair: one move per cycle, and listed values one at a time through the result
// register, each read only once that register is free. A command beat is taken while an
// earlier result still waits in the result register.
module bounded_ordered_list_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bol_in_if.sink      in_i,
  bol_out_if.source   out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = ((CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W) + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_LRD  = 3'd4;
  localparam logic [2:0] S_LLD  = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [CW-1:0]              rem_q, rem_d;
  logic [AW-1:0]              src_q, src_d;
  logic [AW-1:0]              wptr_q, wptr_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic                       pend_q, pend_d;
  logic                       up_q, up_d;
  logic                       ins_q, ins_d;
  logic                       dfront_q, dfront_d;
  logic [bol_pkg::VAL_W-1:0]  val_q, val_d;
  bol_pkg::status_e           res_st_q, res_st_d;
  logic [bol_pkg::VAL_W-1:0]  res_val_q, res_val_d;

  logic                       ov_q;
  bol_pkg::status_e           o_st_q;
  logic [bol_pkg::VAL_W-1:0]  o_val_q;
  logic                       o_last_q;

  logic                       ld;
  bol_pkg::status_e           ld_st;
  logic [bol_pkg::VAL_W-1:0]  ld_val;
  logic                       ld_last;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bol_pkg::VAL_W-1:0]  ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [bol_pkg::VAL_W-1:0]  ram_rdata;

  logic                       in_fire;
  logic                       out_fire;
  logic                       out_free;
  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext1;
  logic [CW-1:0]              cnt_m1;
  logic [CW-1:0]              ins_idx;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = ov_q & out_o.ready;
  assign out_free   = ~ov_q | out_o.ready;
  assign pos_ext    = PW'(in_i.position);
  assign cnt_ext1   = PW'(cnt_q) + PW'(1);
  assign cnt_m1     = cnt_q - CW'(1);

  always_comb begin
    case (in_i.op)
      bol_pkg::OP_INS_FRONT: ins_idx = '0;
      bol_pkg::OP_INS_BACK:  ins_idx = cnt_q;
      default:               ins_idx = CW'(in_i.position - bol_pkg::POS_W'(1));
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    src_d     = src_q;
    wptr_d    = wptr_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    up_d      = up_q;
    ins_d     = ins_q;
    dfront_d  = dfront_q;
    val_d     = val_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    ram_we    = 1'b0;
    ram_waddr = wptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = src_q;
    ld        = 1'b0;
    ld_st     = res_st_q;
    ld_val    = res_val_q;
    ld_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_st_d  = bol_pkg::ST_OK;
          res_val_d = '0;
          pend_d    = 1'b0;
          case (in_i.op)
            bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK, bol_pkg::OP_INS_POS: begin
              if (in_i.op == bol_pkg::OP_INS_POS &&
                  (pos_ext == '0 || pos_ext > cnt_ext1)) begin
                res_st_d = bol_pkg::ST_NOPOS;
                state_d  = S_RESP;
              end else if (cnt_q == CNT_MAX) begin
                res_st_d = bol_pkg::ST_FULL;
                state_d  = S_RESP;
              end else begin
                idx_d   = AW'(ins_idx);
                rem_d   = cnt_q - ins_idx;
                src_d   = AW'(cnt_m1);
                wptr_d  = AW'(cnt_q);
                up_d    = 1'b1;
                ins_d   = 1'b1;
                val_d   = in_i.value;
                cnt_d   = cnt_q + CW'(1);
                state_d = S_MOVE;
              end
            end
            bol_pkg::OP_DEL_FRONT, bol_pkg::OP_DEL_BACK: begin
              if (cnt_q == '0) begin
                res_st_d = bol_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                dfront_d  = (in_i.op == bol_pkg::OP_DEL_FRONT);
                ram_raddr = (in_i.op == bol_pkg::OP_DEL_FRONT) ? '0 : AW'(cnt_m1);
                src_d     = AW'(1);
                wptr_d    = '0;
                rem_d     = cnt_m1;
                up_d      = 1'b0;
                ins_d     = 1'b0;
                cnt_d     = cnt_m1;
                state_d   = S_HEAD;
              end
            end
            bol_pkg::OP_LIST: begin
              if (cnt_q == '0) begin
                res_st_d = bol_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                src_d   = '0;
                rem_d   = cnt_m1;
                state_d = S_LRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_HEAD: begin
        res_val_d = ram_rdata;
        state_d   = dfront_q ? S_MOVE : S_RESP;
      end
      S_MOVE: begin
        if (pend_q) begin
          ram_we = 1'b1;
          wptr_d = up_q ? wptr_q - AW'(1) : wptr_q + AW'(1);
        end
        if (rem_q != '0) begin
          src_d  = up_q ? src_q - AW'(1) : src_q + AW'(1);
          rem_d  = rem_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (ins_q) begin
              ram_we    = 1'b1;
              ram_waddr = idx_q;
              ram_wdata = val_q;
            end
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ld      = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LRD: begin
        if (out_free) begin
          state_d = S_LLD;
        end
      end
      S_LLD: begin
        ld      = 1'b1;
        ld_st   = bol_pkg::ST_OK;
        ld_val  = ram_rdata;
        ld_last = (rem_q == '0);
        if (rem_q == '0) begin
          state_d = S_IDLE;
        end else begin
          src_d   = src_q + AW'(1);
          rem_d   = rem_q - CW'(1);
          state_d = S_LRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      src_q    <= '0;
      wptr_q   <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      up_q     <= 1'b0;
      ins_q    <= 1'b0;
      dfront_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      src_q    <= src_d;
      wptr_q   <= wptr_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      up_q     <= up_d;
      ins_q    <= ins_d;
      dfront_q <= dfront_d;
      if (ld) begin
        ov_q <= 1'b1;
      end else if (out_fire) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    if (ld) begin
      o_st_q   <= ld_st;
      o_val_q  <= ld_val;
      o_last_q <= ld_last;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.status    = o_st_q;
  assign out_o.value_res = o_val_q;
  assign out_o.last      = o_last_q;

  bol_ram #(
    .WIDTH (bol_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("count above depth");

  a_list_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LLD |-> !ov_q)
    else $error("list beat would overwrite a pending result");

  a_list_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LLD && rem_q == '0) |=> (ov_q && o_last_q))
    else $error("final list beat not marked last");

  a_ins_back_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == bol_pkg::OP_INS_BACK && cnt_q != CNT_MAX)
    |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("insert back did not grow the list");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ram_waddr < DEPTH)
    else $error("write beyond list storage");

endmodule

// ===== verif/bounded_ordered_list_core_test.sv =====
// Self-checking testbench for bounded_ordered_list_core: directed edge cases, then
// random fill/drain traffic with bursty commands and result backpressure.
// Depends on bol_pkg, bol_in_if, bol_out_if and the core RTL.
module bounded_ordered_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned HOLD_AT      = 90;
  localparam int unsigned PAUSE_AT     = 180;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES  = 100;

  localparam logic [bol_pkg::POS_W-1:0] POS_MAX = 6'd33;

  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [bol_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [bol_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bol_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [bol_pkg::ST_W-1:0]         status;
    logic signed [bol_pkg::VAL_W-1:0] value;
    logic                             last;
  } result_t;

  class list_scoreboard;
    logic signed [bol_pkg::VAL_W-1:0] held_values [DEPTH];
    int unsigned                      fill;
    int unsigned                      peak_fill;
    result_t                          expected_results [$];
    int unsigned                      errors;
    int unsigned                      beats_checked;
    int unsigned                      commands;
    int unsigned                      status_hits [4];

    function new();
      fill = 0;
      peak_fill = 0;
      errors = 0;
      beats_checked = 0;
      commands = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void expect_beat(bol_pkg::status_e st, logic signed [bol_pkg::VAL_W-1:0] v,
                              logic l);
      result_t r;
      r.status = st;
      r.value  = v;
      r.last   = l;
      expected_results.push_back(r);
      status_hits[st]++;
    endfunction

    function void insert_at(int unsigned idx, logic signed [bol_pkg::VAL_W-1:0] v);
      for (int unsigned i = fill; i > idx; i--) held_values[i] = held_values[i-1];
      held_values[idx] = v;
      fill++;
      if (fill > peak_fill) peak_fill = fill;
      expect_beat(bol_pkg::ST_OK, '0, 1'b1);
    endfunction

    function void note_command(logic [bol_pkg::OP_W-1:0] op,
                               logic signed [bol_pkg::VAL_W-1:0] v,
                               logic [bol_pkg::POS_W-1:0] pos);
      logic signed [bol_pkg::VAL_W-1:0] taken;
      commands++;
      case (op)
        bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK: begin
          if (fill >= DEPTH) expect_beat(bol_pkg::ST_FULL, '0, 1'b1);
          else insert_at((op == bol_pkg::OP_INS_FRONT) ? 0 : fill, v);
        end
        bol_pkg::OP_INS_POS: begin
          if (pos < 1 || pos > fill + 1) expect_beat(bol_pkg::ST_NOPOS, '0, 1'b1);
          else if (fill >= DEPTH) expect_beat(bol_pkg::ST_FULL, '0, 1'b1);
          else insert_at(pos - 1, v);
        end
        bol_pkg::OP_DEL_FRONT: begin
          if (fill == 0) begin
            expect_beat(bol_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            taken = held_values[0];
            for (int unsigned i = 1; i < fill; i++) held_values[i-1] = held_values[i];
            fill--;
            expect_beat(bol_pkg::ST_OK, taken, 1'b1);
          end
        end
        bol_pkg::OP_DEL_BACK: begin
          if (fill == 0) begin
            expect_beat(bol_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            fill--;
            expect_beat(bol_pkg::ST_OK, held_values[fill], 1'b1);
          end
        end
        bol_pkg::OP_LIST: begin
          if (fill == 0) expect_beat(bol_pkg::ST_EMPTY, '0, 1'b1);
          else for (int unsigned i = 0; i < fill; i++)
            expect_beat(bol_pkg::ST_OK, held_values[i], (i + 1 == fill));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [bol_pkg::ST_W-1:0] st,
                               logic signed [bol_pkg::VAL_W-1:0] v, logic l);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d value %0d last %0b",
               st, v, l);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      beats_checked++;
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (v !== want.value) begin
        $error("value_res: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;
  int unsigned burst_left;
  int unsigned idle_cycles;

  list_scoreboard sb;

  bol_in_if  in_bus ();
  bol_out_if out_bus ();

  bounded_ordered_list_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    in_bus.valid    = 1'b0;
    in_bus.op       = '0;
    in_bus.value    = '0;
    in_bus.position = '0;
    out_bus.ready   = 1'b0;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    burst_left      = 0;
    idle_cycles     = 0;
    sb              = new();
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.status, out_bus.value_res, out_bus.last);
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a beat", idle_cycles);
      $display("** bounded_ordered_list_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result-side backpressure: spans of steady, light and heavy stalling, plus one
  // long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          out_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 7) != 0);
          2: out_bus.ready <= ($urandom_range(0, 1) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic issue(input logic [bol_pkg::OP_W-1:0] op,
                       input logic signed [bol_pkg::VAL_W-1:0] v,
                       input logic [bol_pkg::POS_W-1:0] pos);
    if (burst_left == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid    <= 1'b1;
    in_bus.op       <= op;
    in_bus.value    <= v;
    in_bus.position <= pos;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_command(op, v, pos);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [bol_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned overrun;
    int unsigned r;
    bit filling;
    bit grow;
    logic [bol_pkg::OP_W-1:0]  op;
    logic [bol_pkg::POS_W-1:0] pos;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(bol_pkg::OP_DEL_FRONT, '0, '0);
    issue(bol_pkg::OP_DEL_BACK, '0, '0);
    issue(bol_pkg::OP_LIST, '0, '0);
    issue(bol_pkg::OP_INS_POS, 32'sd5, 6'd0);
    issue(bol_pkg::OP_INS_POS, 32'sd6, 6'd2);
    issue(bol_pkg::OP_INS_POS, VAL_MAX, 6'd1);
    issue(bol_pkg::OP_INS_FRONT, VAL_MIN, '0);
    issue(bol_pkg::OP_INS_BACK, -32'sd1, '0);
    issue(bol_pkg::OP_INS_BACK, '0, '0);
    issue(bol_pkg::OP_INS_POS, 32'sh5555_5555, 6'd3);
    issue(bol_pkg::OP_INS_POS, 32'shAAAA_AAAA, 6'd6);
    issue(bol_pkg::OP_INS_POS, 32'sd7, 6'd8);
    issue(bol_pkg::OP_INS_POS, 32'sd8, POS_MAX);
    issue(OP_SPARE_LO, 32'sd9, 6'd1);
    issue(OP_SPARE_HI, 32'sd10, 6'd1);
    issue(bol_pkg::OP_LIST, '0, '0);
    issue(bol_pkg::OP_DEL_FRONT, '0, '0);
    issue(bol_pkg::OP_DEL_BACK, '0, '0);
    issue(bol_pkg::OP_LIST, '0, '0);
    wait_drained();

    // Random part: sweep the list between empty and full, overrunning each bound by a
    // few commands so the full and empty errors get hit.
    n = 0;
    filling = 1'b1;
    overrun = $urandom_range(2, 6);
    while (n < RANDOM_ITEMS) begin
      if (filling ? (sb.fill == DEPTH) : (sb.fill == 0)) begin
        if (overrun > 0) begin
          overrun--;
        end else begin
          filling = !filling;
          overrun = $urandom_range(2, 6);
        end
      end else if ($urandom_range(0, 39) == 0) begin
        filling = !filling;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        issue(($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO, $urandom,
              bol_pkg::POS_W'($urandom_range(0, POS_MAX)));
        continue;
      end
      if (r < 12) begin
        op = bol_pkg::OP_LIST;
      end else begin
        grow = (r < 75) ? filling : !filling;
        if (grow) begin
          case ($urandom_range(0, 2))
            0: op = bol_pkg::OP_INS_FRONT;
            1: op = bol_pkg::OP_INS_BACK;
            default: op = bol_pkg::OP_INS_POS;
          endcase
        end else begin
          op = ($urandom_range(0, 1) != 0) ? bol_pkg::OP_DEL_BACK : bol_pkg::OP_DEL_FRONT;
        end
      end
      if ($urandom_range(0, 4) == 0) pos = bol_pkg::POS_W'($urandom_range(0, POS_MAX));
      else pos = bol_pkg::POS_W'($urandom_range(1, sb.fill + 1));
      issue(op, pick_value(), pos);
      n++;
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d checked result beats; peak fill %0d of %0d.",
             sb.commands, sb.beats_checked, sb.peak_fill, DEPTH);
    $display("Result status mix: ok %0d, empty %0d, bad position %0d, full %0d.",
             sb.status_hits[bol_pkg::ST_OK], sb.status_hits[bol_pkg::ST_EMPTY],
             sb.status_hits[bol_pkg::ST_NOPOS], sb.status_hits[bol_pkg::ST_FULL]);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("** bounded_ordered_list_core: PASSED **");
    end else begin
      $display("** bounded_ordered_list_core: FAILED **");
    end
    $finish;
  end

endmodule
